// ===== src/nearest_point_search_3d_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Nearest point search assertion macros
// Shared concurrent assertion forms for the nearest point search unit.
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_SEARCH_3D_UNIT_MACROS_SVH
`define NEAREST_POINT_SEARCH_3D_UNIT_MACROS_SVH

// same-cycle implication
`define NPS3D_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NPS3D_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/nps3d_pkg.sv =====
// ----------------------------------------------------------------------------
// nps3d_pkg
// Codes, defaults and controller/datapath handshake types for the nearest
// point search unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nps3d_pkg;

	localparam int DEF_MAX_POINTS = 256;
	localparam int DEF_COORD_BITS = 24;
	localparam int INDEX_OUT_W    = 8;

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_QUERY  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic       capture;
		logic       append_wr;
		logic       clear;
		logic       scan_start;
		logic       scan_rd;
		logic       load_res;
		logic       res_query;
		logic [1:0] res_status;
	} ctl_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic scan_last;
		logic busy;
	} ctl_sts_t;

endpackage

// ===== src/nearest_point_search_3d_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_point_search_3d_unit
// Point table with append, clear and nearest-point query by squared
// Euclidean distance; ties keep the lowest index.
//
//   channel  | dir | tdata (low bit up)                          | tuser
//   ---------+-----+---------------------------------------------+---------
//   s_axis   | in  | px, py, pz                                  | cmd
//   m_axis   | out | nearest_index, nearest_x/y/z, min_sq_dist   | status
//
// Append, clear and unused commands: the result loads in the execute state once the output register is free.
// Query: one stored point read per cycle from the point RAM feeds a four-stage
// distance pipeline, and the result loads once the pipeline has drained.
// Reset clears the point count; the point RAM needs no clearing pass.
// A result waits in the output register; the next item is taken once it loads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_point_search_3d_unit #(
	parameter int MAX_POINTS = nps3d_pkg::DEF_MAX_POINTS,
	parameter int COORD_BITS = nps3d_pkg::DEF_COORD_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// px, py, pz
	input  logic [((3*COORD_BITS+7)/8)*8-1:0]      s_tdata,
	// cmd
	input  logic [1:0]                             s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// nearest_index, nearest_x, nearest_y, nearest_z, min_sq_distance
	output logic [((5*COORD_BITS+17)/8)*8-1:0]     m_tdata,
	// status
	output logic [1:0]                             m_tuser
);
	import nps3d_pkg::*;

	localparam int M_USED = INDEX_OUT_W + 5 * COORD_BITS + 2;
	localparam int M_W    = ((5 * COORD_BITS + 17) / 8) * 8;

	ctl_cmd_t              cmd;
	ctl_sts_t              sts;
	logic [7:0]            res_index;
	logic [COORD_BITS-1:0] res_x, res_y, res_z;
	logic [2*COORD_BITS+1:0] res_dist;
	logic [M_USED-1:0]     m_payload;

	nps3d_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.in_cmd  (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	nps3d_dp #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_x      (s_tdata[COORD_BITS-1:0]),
		.in_y      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.in_z      (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
		.res_status(m_tuser),
		.res_index (res_index),
		.res_x     (res_x),
		.res_y     (res_y),
		.res_z     (res_z),
		.res_dist  (res_dist)
	);

	assign m_payload = {res_dist, res_z, res_y, res_x, res_index};
	assign m_tdata   = M_W'(m_payload);

endmodule

// ===== src/nps3d_ram.sv =====
// ----------------------------------------------------------------------------
// nps3d_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nps3d_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/nps3d_ctrl.sv =====
// ----------------------------------------------------------------------------
// nps3d_ctrl
// Command sequencer: takes items, steps the datapath through append, clear
// and scan, and owns the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nps3d_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [1:0]          in_cmd,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  nps3d_pkg::ctl_sts_t sts,
	output nps3d_pkg::ctl_cmd_t cmd
);
	import nps3d_pkg::*;

	`include "nearest_point_search_3d_unit_macros.svh"

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DRAIN
	} state_t;

	state_t     state_q;
	logic [1:0] cmd_q;
	logic       s_tready_q;
	logic       m_tvalid_q;
	logic       out_free;
	logic       accept;

	assign s_tready = s_tready_q;
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready_q;

	always_comb begin
		cmd = '0;
		cmd.capture = accept;
		case (state_q)
			S_EXEC: begin
				case (cmd_q)
					CMD_QUERY: begin
						if (sts.empty) begin
							cmd.load_res   = out_free;
							cmd.res_status = ST_EMPTY;
						end else begin
							cmd.scan_start = 1'b1;
						end
					end
					CMD_APPEND: begin
						cmd.load_res   = out_free;
						cmd.append_wr  = out_free && !sts.full;
						cmd.res_status = sts.full ? ST_FULL : ST_OK;
					end
					CMD_CLEAR: begin
						cmd.load_res   = out_free;
						cmd.clear      = out_free;
						cmd.res_status = ST_OK;
					end
					default: begin
						cmd.load_res   = out_free;
						cmd.res_status = ST_OK;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
			end
			S_DRAIN: begin
				cmd.load_res   = out_free && !sts.busy;
				cmd.res_query  = 1'b1;
				cmd.res_status = ST_OK;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmd_q      <= CMD_APPEND;
			s_tready_q <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.load_res) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q      <= in_cmd;
						s_tready_q <= 1'b0;
						state_q    <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.scan_start) begin
						state_q <= S_SCAN;
					end else if (cmd.load_res) begin
						s_tready_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (sts.scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (cmd.load_res) begin
						s_tready_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`NPS3D_ASSERT_IMP(a_load_free, clk, arst_n, cmd.load_res, out_free, "result loaded over a pending item")
	`NPS3D_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, !s_tready_q, "second item taken while busy")
	`NPS3D_ASSERT_IMP(a_scan_quiet, clk, arst_n, state_q == S_SCAN, !m_tvalid_q || !s_tready_q, "ready during scan")

endmodule

// ===== src/nps3d_dp.sv =====
// ----------------------------------------------------------------------------
// nps3d_dp
// Point store, scan address counter, distance pipeline, running minimum and
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nps3d_dp #(
	parameter int MAX_POINTS = nps3d_pkg::DEF_MAX_POINTS,
	parameter int COORD_BITS = nps3d_pkg::DEF_COORD_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  nps3d_pkg::ctl_cmd_t       cmd,
	output nps3d_pkg::ctl_sts_t       sts,
	input  logic [COORD_BITS-1:0]     in_x,
	input  logic [COORD_BITS-1:0]     in_y,
	input  logic [COORD_BITS-1:0]     in_z,
	output logic [1:0]                res_status,
	output logic [7:0]                res_index,
	output logic [COORD_BITS-1:0]     res_x,
	output logic [COORD_BITS-1:0]     res_y,
	output logic [COORD_BITS-1:0]     res_z,
	output logic [2*COORD_BITS+1:0]   res_dist
);
	import nps3d_pkg::*;

	`include "nearest_point_search_3d_unit_macros.svh"

	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int CNT_W  = IDX_W + 1;
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int DIST_W = SQ_W + 2;
	localparam int PT_W   = 3 * COORD_BITS;

	logic [COORD_BITS-1:0] qx_q, qy_q, qz_q;
	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      addr_q;
	logic [PT_W-1:0]       rdata;

	logic                  v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0]      idx_s1, idx_s2, idx_s3, idx_s4;
	logic [PT_W-1:0]       pt_s2, pt_s3, pt_s4;
	logic [DIFF_W-1:0]     dx_s2, dy_s2, dz_s2;
	logic [SQ_W-1:0]       sx_s3, sy_s3, sz_s3;
	logic [DIST_W-1:0]     sum_s4;

	logic [DIST_W-1:0]     best_d_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [PT_W-1:0]       best_pt_q;
	logic                  best_take;

	logic [2*DIFF_W-1:0]   px_prod, py_prod, pz_prod;
	logic [IDX_W+7:0]      idx_ext;

	assign sts.full      = (count_q == CNT_W'(MAX_POINTS));
	assign sts.empty     = (count_q == '0);
	assign sts.scan_last = (CNT_W'(addr_q) == count_q - 1'b1);
	assign sts.busy      = v_s1 || v_s2 || v_s3 || v_s4;

	nps3d_ram #(
		.WIDTH(PT_W),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (cmd.append_wr),
		.waddr(count_q[IDX_W-1:0]),
		.wdata({qz_q, qy_q, qx_q}),
		.re   (cmd.scan_rd),
		.raddr(addr_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			addr_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.append_wr) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.scan_start) begin
				addr_q <= '0;
			end else if (cmd.scan_rd) begin
				addr_q <= addr_q + 1'b1;
			end
			v_s1 <= cmd.scan_rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign px_prod = $signed(dx_s2) * $signed(dx_s2);
	assign py_prod = $signed(dy_s2) * $signed(dy_s2);
	assign pz_prod = $signed(dz_s2) * $signed(dz_s2);

	assign best_take = v_s4 && ((idx_s4 == '0) || (sum_s4 < best_d_q));
	assign idx_ext   = {8'b0, best_idx_q};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			qx_q <= in_x;
			qy_q <= in_y;
			qz_q <= in_z;
		end
		idx_s1 <= addr_q;

		idx_s2 <= idx_s1;
		pt_s2  <= rdata;
		dx_s2  <= {qx_q[COORD_BITS-1], qx_q}
			- {rdata[COORD_BITS-1], rdata[COORD_BITS-1:0]};
		dy_s2  <= {qy_q[COORD_BITS-1], qy_q}
			- {rdata[2*COORD_BITS-1], rdata[2*COORD_BITS-1:COORD_BITS]};
		dz_s2  <= {qz_q[COORD_BITS-1], qz_q}
			- {rdata[PT_W-1], rdata[PT_W-1:2*COORD_BITS]};

		idx_s3 <= idx_s2;
		pt_s3  <= pt_s2;
		sx_s3  <= px_prod[SQ_W-1:0];
		sy_s3  <= py_prod[SQ_W-1:0];
		sz_s3  <= pz_prod[SQ_W-1:0];

		idx_s4 <= idx_s3;
		pt_s4  <= pt_s3;
		sum_s4 <= DIST_W'(sx_s3) + DIST_W'(sy_s3) + DIST_W'(sz_s3);

		if (best_take) begin
			best_d_q   <= sum_s4;
			best_idx_q <= idx_s4;
			best_pt_q  <= pt_s4;
		end

		if (cmd.load_res) begin
			res_status <= cmd.res_status;
			if (cmd.res_query) begin
				res_index <= idx_ext[7:0];
				res_x     <= best_pt_q[COORD_BITS-1:0];
				res_y     <= best_pt_q[2*COORD_BITS-1:COORD_BITS];
				res_z     <= best_pt_q[PT_W-1:2*COORD_BITS];
				res_dist  <= best_d_q;
			end else begin
				res_index <= '0;
				res_x     <= '0;
				res_y     <= '0;
				res_z     <= '0;
				res_dist  <= '0;
			end
		end
	end

	`NPS3D_ASSERT_IMP(a_no_append_full, clk, arst_n, cmd.append_wr, !sts.full, "append into full store")
	`NPS3D_ASSERT_IMP(a_scan_nonempty, clk, arst_n, cmd.scan_rd, !sts.empty, "scan of empty store")
	`NPS3D_ASSERT_NXT(a_first_taken, clk, arst_n, v_s4 && idx_s4 == '0, best_idx_q == '0, "first point not taken")

endmodule
